// ===== sv/nvkt_pkg.sv =====
// ----------------------------------------------------------------------------
// nvkt_pkg
// Shared constants for the named vector key table: command and status codes,
// stream field layout and parameter defaults.
// ----------------------------------------------------------------------------
package nvkt_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_BYTES_DEF = 8;

    // command codes
    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 64;
    localparam int COMP_W  = 32;
    localparam int CNT_W   = 5;
    localparam int IN_W    = 168;
    localparam int OUT_W   = 104;

endpackage

// ===== sv/named_vector_key_table.sv =====
// ----------------------------------------------------------------------------
// named_vector_key_table
// Keyed table of named three-component entries with store, find and clear.
// ----------------------------------------------------------------------------
// Commands enter on the s_ stream, one request at a time; each gives exactly
// one response on the m_ stream. A store replaces the first entry whose key
// matches or appends a new one, reporting full when there is no room. A find
// returns the first matching entry's components or not-found with zeros. A
// clear empties the table.
// Keys are compared as strings: only the low KEY_BYTES bytes count and bytes
// after the first zero byte are ignored.
// Scan: store and find scan the held entries one at a time through a
// single-port key/value memory, reading each entry and then comparing it,
// and stop early on a match; clear and unused codes, which answer OK, go
// straight to the response. s_tready is high only between commands, so the
// next request is taken only once the response register has been loaded.
// The response sits in an output register; a stalled receiver holds the
// block at the end of the next command until the register is taken.
// Reset empties the table at once; the memories themselves are not cleared.
// ----------------------------------------------------------------------------
module named_vector_key_table #(
    parameter int DEPTH     = nvkt_pkg::DEPTH_DEF,
    parameter int KEY_BYTES = nvkt_pkg::KEY_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [nvkt_pkg::IN_W-1:0]  s_tdata,  // opcode, key_name, in_x, in_y, in_z, pad
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [nvkt_pkg::OUT_W-1:0] m_tdata   // status, out_x, out_y, out_z, entry_count, pad
);

    localparam int KW     = 8 * KEY_BYTES;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VAL_W  = 3 * nvkt_pkg::COMP_W;
    localparam int OUT_PAD = nvkt_pkg::OUT_W - 2 - VAL_W - nvkt_pkg::CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] cnt_reg, cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [nvkt_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic [1:0]        op_reg, op_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [VAL_W-1:0]  res_val_reg, res_val_next;

    logic [KW-1:0]     key_mem [0:DEPTH-1];
    logic [VAL_W-1:0]  val_mem [0:DEPTH-1];
    logic [KW-1:0]     key_rd_reg;
    logic [VAL_W-1:0]  val_rd_reg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    logic [KW-1:0]     key_norm;
    logic [63:0]       key_in;
    logic              accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign key_in   = s_tdata[65:2];

    // string view of the key: bytes after the first zero byte read as zero
    always_comb
    begin
        logic alive;
        alive    = 1'b1;
        key_norm = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            if (key_in[8*b +: 8] == 8'd0)
                alive = 1'b0;
            if (alive)
                key_norm[8*b +: 8] = key_in[8*b +: 8];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        mem_we          = 1'b0;
        mem_addr        = cnt_reg[IDX_W-1:0];

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = s_tdata[1:0];
                    key_next        = key_norm;
                    val_next        = s_tdata[161:66];
                    res_status_next = nvkt_pkg::ST_OK;
                    res_val_next    = '0;
                    cnt_next        = '0;
                    case (s_tdata[1:0])
                        nvkt_pkg::OP_STORE,
                        nvkt_pkg::OP_FIND:  state_next = S_RD;
                        nvkt_pkg::OP_CLEAR:
                        begin
                            fill_next  = '0;
                            state_next = S_RESP;
                        end
                        default:            state_next = S_RESP;
                    endcase
                end
            end
            S_RD:
            begin
                if (cnt_reg == fill_reg)
                begin
                    // scanned every held entry without a match
                    state_next = S_RESP;
                    if (op_reg == nvkt_pkg::OP_FIND)
                        res_status_next = nvkt_pkg::ST_NOTFOUND;
                    else if (fill_reg < FILL_W'(DEPTH))
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = fill_reg[IDX_W-1:0];
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                        res_status_next = nvkt_pkg::ST_FULL;
                end
                else
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                if (key_rd_reg == key_reg)
                begin
                    state_next = S_RESP;
                    if (op_reg == nvkt_pkg::OP_FIND)
                        res_val_next = val_rd_reg;
                    else
                        mem_we = 1'b1;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{OUT_PAD{1'b0}}, nvkt_pkg::CNT_W'(fill_reg),
                                     res_val_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg    <= m_tdata_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_val_reg    <= res_val_next;
    end

    // single-port key and value memories, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_addr] <= key_reg;
            val_mem[mem_addr] <= val_reg;
        end
        key_rd_reg <= key_mem[mem_addr];
        val_rd_reg <= val_mem[mem_addr];
    end

endmodule

// ===== dv/nvkt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvkt_checker
// Watches both streams of the key table, tracks its own copy of the table and
// compares every response field by field with the oldest one predicted.
// ----------------------------------------------------------------------------
module nvkt_checker #(
    parameter int DEPTH     = nvkt_pkg::DEPTH_DEF,
    parameter int KEY_BYTES = nvkt_pkg::KEY_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [nvkt_pkg::IN_W-1:0]  s_tdata,  // opcode, key_name, in_x, in_y, in_z, pad
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [nvkt_pkg::OUT_W-1:0] m_tdata,  // status, out_x, out_y, out_z, entry_count, pad
    output int                         fail_cnt,
    output int                         pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [4:0]  count;
    } table_answer_t;

    logic [63:0]   key_tab [DEPTH];
    logic [31:0]   x_tab   [DEPTH];
    logic [31:0]   y_tab   [DEPTH];
    logic [31:0]   z_tab   [DEPTH];
    int            fill;
    table_answer_t answers_due [$];

    // key as a string: stop at the first zero byte or at KEY_BYTES
    function automatic logic [63:0] canon_key(logic [63:0] k);
        logic [63:0] r;
        bit          ended;
        r     = '0;
        ended = 1'b0;
        for (int b = 0; b < 8; b++)
        begin
            if (b >= KEY_BYTES || k[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                r[8*b +: 8] = k[8*b +: 8];
        end
        return r;
    endfunction

    function automatic int find_slot(logic [63:0] key);
        for (int i = 0; i < fill; i++)
        begin
            if (key_tab[i] == key)
                return i;
        end
        return -1;
    endfunction

    task automatic run_command(input logic [1:0] op, input logic [63:0] key_raw,
                               input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, output table_answer_t a);
        logic [63:0] key;
        int          hit;
        key = canon_key(key_raw);
        a   = '0;
        case (op)
            nvkt_pkg::OP_STORE:
            begin
                hit = find_slot(key);
                if (hit < 0 && fill < DEPTH)
                begin
                    hit          = fill;
                    key_tab[hit] = key;
                    fill++;
                end
                if (hit >= 0)
                begin
                    x_tab[hit] = x;
                    y_tab[hit] = y;
                    z_tab[hit] = z;
                end
                else
                    a.status = nvkt_pkg::ST_FULL;
            end
            nvkt_pkg::OP_FIND:
            begin
                hit = find_slot(key);
                if (hit >= 0)
                begin
                    a.x = x_tab[hit];
                    a.y = y_tab[hit];
                    a.z = z_tab[hit];
                end
                else
                    a.status = nvkt_pkg::ST_NOTFOUND;
            end
            nvkt_pkg::OP_CLEAR:
                fill = 0;
            default:
                ;
        endcase
        a.count = fill[4:0];
    endtask

    function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_answer_t want;
        table_answer_t got;
        int            errs;
        if (!rst_n)
        begin
            fill = 0;
            answers_due.delete();
            fail_cnt <= 0;
            pending  <= 0;
        end
        else
        begin
            errs = 0;
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[1:0];
                got.x      = m_tdata[33:2];
                got.y      = m_tdata[65:34];
                got.z      = m_tdata[97:66];
                got.count  = m_tdata[102:98];
                if (answers_due.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %h",
                             $time, got);
                    errs++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    errs += field_bad("status", 32'(want.status), 32'(got.status));
                    errs += field_bad("out_x", want.x, got.x);
                    errs += field_bad("out_y", want.y, got.y);
                    errs += field_bad("out_z", want.z, got.z);
                    errs += field_bad("entry_count", 32'(want.count), 32'(got.count));
                end
            end
            if (s_tvalid && s_tready)
            begin
                run_command(s_tdata[1:0], s_tdata[65:2], s_tdata[97:66],
                            s_tdata[129:98], s_tdata[161:130], want);
                answers_due.push_back(want);
            end
            fail_cnt <= fail_cnt + errs;
            pending  <= answers_due.size();
        end
    end

endmodule

// ===== dv/named_vector_key_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// named_vector_key_table_tb
// Drives store, find, clear and unused-code requests into the key table with
// random gaps and response stalls; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module named_vector_key_table_tb;

    localparam int          LIMIT      = 400000;
    localparam int          TAIL       = 60;
    localparam int          POOL_SIZE  = 20;
    localparam int          PHASE_REQS = 238;
    localparam logic [1:0]  OP_SPARE   = 2'd3;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [nvkt_pkg::IN_W-1:0]    s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [nvkt_pkg::OUT_W-1:0]   m_tdata;
    int                           fail_cnt;
    int                           pending;
    int unsigned                  cycles = 0;
    bit                           steady = 1'b0;
    logic [63:0]                  names [POOL_SIZE];

    named_vector_key_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nvkt_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .fail_cnt (fail_cnt),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 16);
    end

    task automatic send_cmd(input logic [1:0] op, input logic [63:0] key,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, z, y, x, key, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // wait until every predicted response has come back
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // random junk above the terminating zero byte must not change the name
    function automatic logic [63:0] dress_key(logic [63:0] base);
        int len;
        len = 8;
        for (int b = 7; b >= 0; b--)
        begin
            if (base[8*b +: 8] == 8'h00)
                len = b;
        end
        if (len < 7 && $urandom_range(0, 2) == 0)
            return base | ({$urandom, $urandom} << (8 * (len + 1)));
        return base;
    endfunction

    task automatic build_names();
        int          len;
        logic [63:0] k;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            len = $urandom_range(0, 8);
            k   = '0;
            for (int b = 0; b < len; b++)
                k[8*b +: 8] = 8'($urandom_range(1, 255));
            names[i] = k;
        end
    endtask

    task automatic random_cmd();
        int          pick;
        logic [1:0]  op;
        logic [63:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            op = nvkt_pkg::OP_CLEAR;
        else if (pick < 4)
            op = OP_SPARE;
        else if (pick < 50)
            op = nvkt_pkg::OP_STORE;
        else
            op = nvkt_pkg::OP_FIND;
        if ($urandom_range(0, 99) < 88)
            key = dress_key(names[$urandom_range(0, POOL_SIZE - 1)]);
        else
            key = {$urandom, $urandom};
        send_cmd(op, key, rand_word(), rand_word(), rand_word());
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unused code, empty table, empty name, junk after terminator
        send_cmd(OP_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        send_cmd(nvkt_pkg::OP_FIND, 64'h0, 32'h0, 32'h0, 32'h0);
        send_cmd(nvkt_pkg::OP_STORE, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        send_cmd(nvkt_pkg::OP_STORE, 64'hA5A5_0000_0000_0041, 32'h3F80_0000,
                 32'hBF80_0000, 32'h7F80_0000);
        send_cmd(nvkt_pkg::OP_FIND, 64'h0000_0000_0000_0041, 32'h0, 32'h0, 32'h0);
        send_cmd(nvkt_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000,
                 32'h0000_0001, 32'h7FFF_FFFF);
        send_cmd(nvkt_pkg::OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // fill the table up to its last entry
        for (int i = 0; i < 13; i++)
            send_cmd(nvkt_pkg::OP_STORE, {48'b0, 8'h30 + 8'(i), 8'h4E},
                     $urandom, $urandom, $urandom);
        send_cmd(nvkt_pkg::OP_STORE, 64'h0000_0000_0000_005A, 32'h1, 32'h2, 32'h3);
        send_cmd(nvkt_pkg::OP_STORE, 64'h0000_0000_0000_0041, 32'h0, 32'h0, 32'h0);
        send_cmd(nvkt_pkg::OP_FIND, 64'h1234_5678_0000_0041, 32'h0, 32'h0, 32'h0);
        send_cmd(nvkt_pkg::OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_cmd(nvkt_pkg::OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0);
        s_tvalid <= 1'b0;
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            build_names();
            steady = (phase == 1);
            for (int n = 0; n < PHASE_REQS; n++)
                random_cmd();
            steady = 1'b0;
            s_tvalid <= 1'b0;
            drain();
        end

        repeat (TAIL) @(posedge clk);
        if (fail_cnt == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== named_vector_key_table.f =====
sv/nvkt_pkg.sv
sv/named_vector_key_table.sv
dv/nvkt_checker.sv
dv/named_vector_key_table_tb.sv
